[src/mpbm_pkg.sv]
// Shared constants, opcodes and the command type of the multi-pattern byte matcher.
// No dependencies; every other file of the block but mpbm_ram uses this package.
package mpbm_pkg;

    localparam int OPCODE_WIDTH = 3;
    localparam int SYM_WIDTH    = 8;
    localparam int STATE_WIDTH  = 10;
    localparam int PAT_WIDTH    = 16;
    localparam int POS_WIDTH    = 32;
    localparam int LINK_WIDTH   = STATE_WIDTH + 1;
    localparam int ENTRY_WIDTH  = LINK_WIDTH + PAT_WIDTH;

    localparam int STATE_COUNT_DEF          = 1024;
    localparam int ALPHABET_DEF             = 256;
    localparam int OUTPUT_ENTRIES_DEF       = 1024;
    localparam int MAX_MATCHES_PER_BYTE_DEF = 64;
    localparam int QUEUE_DEPTH              = 4;

    localparam logic [OPCODE_WIDTH-1:0] OP_SCAN    = 3'd0;
    localparam logic [OPCODE_WIDTH-1:0] OP_GOTO    = 3'd1;
    localparam logic [OPCODE_WIDTH-1:0] OP_HEAD    = 3'd2;
    localparam logic [OPCODE_WIDTH-1:0] OP_SUFFIX  = 3'd3;
    localparam logic [OPCODE_WIDTH-1:0] OP_ENTRY   = 3'd4;
    localparam logic [OPCODE_WIDTH-1:0] OP_RESTART = 3'd5;

    // A classified item as it travels from the front end to the back end.
    // The link field holds the valid flag in its top bit.
    typedef struct packed {
        logic [OPCODE_WIDTH-1:0] op;
        logic [SYM_WIDTH-1:0]    sym;
        logic [STATE_WIDTH-1:0]  sidx;
        logic [STATE_WIDTH-1:0]  eidx;
        logic [LINK_WIDTH-1:0]   link;
        logic [PAT_WIDTH-1:0]    pattern;
    } t_cmd;

endpackage

[src/mpbm_if.sv]
// Valid/ready channel interfaces for the input items and the match results.
// Depends on mpbm_pkg for the field widths.
interface mpbm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [mpbm_pkg::OPCODE_WIDTH-1:0]    opcode;
    logic [mpbm_pkg::SYM_WIDTH-1:0]       scan_byte;
    logic [mpbm_pkg::STATE_WIDTH-1:0]     state_index;
    logic [mpbm_pkg::STATE_WIDTH-1:0]     entry_index;
    logic [mpbm_pkg::STATE_WIDTH-1:0]     link_value;
    logic                                 link_valid;
    logic [mpbm_pkg::PAT_WIDTH-1:0]       pattern_number;

    modport source (output valid, opcode, scan_byte, state_index, entry_index,
                    link_value, link_valid, pattern_number, input ready);
    modport sink (input valid, opcode, scan_byte, state_index, entry_index,
                  link_value, link_valid, pattern_number, output ready);
endinterface

interface mpbm_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [mpbm_pkg::POS_WIDTH-1:0]       match_end;
    logic [mpbm_pkg::PAT_WIDTH-1:0]       match_pattern;
    logic                                 last_of_run;
    logic                                 truncated;

    modport source (output valid, match_end, match_pattern, last_of_run, truncated,
                    input ready);
    modport sink (input valid, match_end, match_pattern, last_of_run, truncated,
                  output ready);
endinterface

[src/mpbm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mpbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[src/mpbm_front.sv]
// Front end: takes input beats, drops items that do nothing and forwards the rest.
// Depends on mpbm_pkg and mpbm_if.
module mpbm_front #(
    parameter int STATE_COUNT    = mpbm_pkg::STATE_COUNT_DEF,
    parameter int ALPHABET       = mpbm_pkg::ALPHABET_DEF,
    parameter int OUTPUT_ENTRIES = mpbm_pkg::OUTPUT_ENTRIES_DEF
) (
    mpbm_in_if.sink         i_in,
    input  logic            i_full,
    output logic            o_push,
    output mpbm_pkg::t_cmd  o_cmd
);
    import mpbm_pkg::*;

    logic sidx_ok;
    logic sym_ok;
    logic eidx_ok;
    logic keep;

    assign sidx_ok = 32'(i_in.state_index) < 32'(STATE_COUNT);
    assign sym_ok  = 32'(i_in.scan_byte) < 32'(ALPHABET);
    assign eidx_ok = 32'(i_in.entry_index) < 32'(OUTPUT_ENTRIES);

    // Writes beyond the tables and unused opcodes are accepted and dropped here.
    always_comb begin
        case (i_in.opcode)
            OP_SCAN, OP_RESTART: keep = 1'b1;
            OP_GOTO:             keep = sidx_ok && sym_ok;
            OP_HEAD, OP_SUFFIX:  keep = sidx_ok;
            OP_ENTRY:            keep = eidx_ok;
            default:             keep = 1'b0;
        endcase
    end

    assign i_in.ready    = !i_full;
    assign o_push        = i_in.valid && !i_full && keep;
    assign o_cmd.op      = i_in.opcode;
    assign o_cmd.sym     = i_in.scan_byte;
    assign o_cmd.sidx    = i_in.state_index;
    assign o_cmd.eidx    = i_in.entry_index;
    assign o_cmd.link    = {i_in.link_valid, i_in.link_value};
    assign o_cmd.pattern = i_in.pattern_number;
endmodule

[src/mpbm_fifo.sv]
// Short command queue between the front end and the back end.
// Depends on mpbm_pkg for the command type.
module mpbm_fifo #(
    parameter int DEPTH = mpbm_pkg::QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mpbm_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output mpbm_pkg::t_cmd  o_cmd
);
    import mpbm_pkg::*;

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wptr;
    logic [PW-1:0] n_rptr;
    logic [CW-1:0] n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (32'(r_count) == 32'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (32'(r_wptr) == 32'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (32'(r_rptr) == 32'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end
endmodule

[src/mpbm_back.sv]
// Back end: table writes, automaton step, suffix-chain and output-list walk, results.
// Depends on mpbm_pkg, mpbm_if and mpbm_ram.
module mpbm_back #(
    parameter int STATE_COUNT          = mpbm_pkg::STATE_COUNT_DEF,
    parameter int ALPHABET             = mpbm_pkg::ALPHABET_DEF,
    parameter int OUTPUT_ENTRIES       = mpbm_pkg::OUTPUT_ENTRIES_DEF,
    parameter int MAX_MATCHES_PER_BYTE = mpbm_pkg::MAX_MATCHES_PER_BYTE_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  mpbm_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    mpbm_out_if.source      o_out
);
    import mpbm_pkg::*;

    localparam int STATE_LIM  = 1 << STATE_WIDTH;
    localparam int STATE_N    = (STATE_COUNT < STATE_LIM) ? STATE_COUNT : STATE_LIM;
    localparam int ENTRY_N    = (OUTPUT_ENTRIES < STATE_LIM) ? OUTPUT_ENTRIES : STATE_LIM;
    localparam int GOTO_DEPTH = STATE_N * ALPHABET;
    localparam int GAW        = (GOTO_DEPTH > 1) ? $clog2(GOTO_DEPTH) : 1;
    localparam int SAW        = (STATE_N > 1) ? $clog2(STATE_N) : 1;
    localparam int EAW        = (ENTRY_N > 1) ? $clog2(ENTRY_N) : 1;
    localparam int CHAIN_W    = $clog2(STATE_COUNT + 1);
    localparam int ENT_W      = $clog2(OUTPUT_ENTRIES + 1);
    localparam int CNT_W      = $clog2(MAX_MATCHES_PER_BYTE + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GOTO  = 3'd1;
    localparam logic [2:0] S_HEAD  = 3'd2;
    localparam logic [2:0] S_ENTRY = 3'd3;
    localparam logic [2:0] S_NEXT  = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [STATE_WIDTH-1:0] r_cur, n_cur;
    logic [POS_WIDTH-1:0]   r_pos, n_pos;
    logic [POS_WIDTH-1:0]   r_end, n_end;
    logic                   r_sym_ok, n_sym_ok;
    logic [CHAIN_W-1:0]     r_chain, n_chain;
    logic [ENT_W-1:0]       r_ent, n_ent;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_pend_valid, n_pend_valid;
    logic [PAT_WIDTH-1:0]   r_pend_pat, n_pend_pat;
    logic                   r_out_valid, n_out_valid;
    logic [POS_WIDTH-1:0]   r_out_end, n_out_end;
    logic [PAT_WIDTH-1:0]   r_out_pat, n_out_pat;
    logic                   r_out_last, n_out_last;
    logic                   r_out_trunc, n_out_trunc;

    logic                   goto_we, goto_re;
    logic [GAW-1:0]         goto_waddr, goto_raddr;
    logic [STATE_WIDTH-1:0] goto_wdata, goto_rd;
    logic                   head_we, suf_we, hs_re;
    logic [SAW-1:0]         hs_raddr;
    logic [LINK_WIDTH-1:0]  head_rd, suf_rd;
    logic                   ent_we, ent_re;
    logic [EAW-1:0]         ent_raddr;
    logic [ENTRY_WIDTH-1:0] ent_rd;

    logic                   slot_free;
    logic                   head_ok, suf_ok, ent_nx_ok;
    logic [CHAIN_W-1:0]     chain_inc, adv_cnt;
    logic [ENT_W-1:0]       ent_inc;
    logic                   adv_ok;
    logic                   finish, trunc, done;
    logic [STATE_WIDTH-1:0] goto_next;
    logic [31:0]            goto_rfull, goto_wfull;

    assign slot_free = !r_out_valid || o_out.ready;
    assign head_ok   = head_rd[LINK_WIDTH-1]
                       && 32'(head_rd[STATE_WIDTH-1:0]) < 32'(OUTPUT_ENTRIES);
    assign suf_ok    = suf_rd[LINK_WIDTH-1]
                       && 32'(suf_rd[STATE_WIDTH-1:0]) < 32'(STATE_COUNT);
    assign ent_nx_ok = ent_rd[ENTRY_WIDTH-1]
                       && 32'(ent_rd[ENTRY_WIDTH-2:PAT_WIDTH]) < 32'(OUTPUT_ENTRIES);
    assign chain_inc = r_chain + CHAIN_W'(1);
    assign ent_inc   = r_ent + ENT_W'(1);
    assign adv_cnt   = (r_state == S_NEXT) ? r_chain : chain_inc;
    assign adv_ok    = suf_ok && 32'(adv_cnt) < 32'(STATE_COUNT);
    assign goto_next = (r_sym_ok && 32'(goto_rd) < 32'(STATE_COUNT)) ? goto_rd : '0;
    assign goto_rfull = 32'(r_cur) * 32'(ALPHABET) + 32'(i_cmd.sym);
    assign goto_wfull = 32'(i_cmd.sidx) * 32'(ALPHABET) + 32'(i_cmd.sym);
    assign goto_raddr = goto_rfull[GAW-1:0];
    assign goto_waddr = goto_wfull[GAW-1:0];
    assign goto_wdata = i_cmd.link[LINK_WIDTH-1] ? i_cmd.link[STATE_WIDTH-1:0] : '0;

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_pos        = r_pos;
        n_end        = r_end;
        n_sym_ok     = r_sym_ok;
        n_chain      = r_chain;
        n_ent        = r_ent;
        n_count      = r_count;
        n_pend_valid = r_pend_valid;
        n_pend_pat   = r_pend_pat;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_end    = r_out_end;
        n_out_pat    = r_out_pat;
        n_out_last   = r_out_last;
        n_out_trunc  = r_out_trunc;
        goto_we      = 1'b0;
        goto_re      = 1'b0;
        head_we      = 1'b0;
        suf_we       = 1'b0;
        hs_re        = 1'b0;
        hs_raddr     = goto_next[SAW-1:0];
        ent_we       = 1'b0;
        ent_re       = 1'b0;
        ent_raddr    = head_rd[EAW-1:0];
        finish       = 1'b0;
        trunc        = 1'b0;
        done         = 1'b0;
        o_cmd_pop    = 1'b0;

        case (r_state)
            S_IDLE: begin
                done = 1'b1;
            end
            S_GOTO: begin
                n_cur    = goto_next;
                hs_re    = 1'b1;
                hs_raddr = goto_next[SAW-1:0];
                n_chain  = '0;
                n_ent    = '0;
                n_count  = '0;
                n_state  = S_HEAD;
            end
            S_HEAD, S_NEXT: begin
                if (r_state == S_HEAD && head_ok && 32'(r_ent) < 32'(OUTPUT_ENTRIES)) begin
                    ent_re    = 1'b1;
                    ent_raddr = head_rd[EAW-1:0];
                    n_chain   = chain_inc;
                    n_state   = S_ENTRY;
                end else if (adv_ok) begin
                    hs_re    = 1'b1;
                    hs_raddr = suf_rd[SAW-1:0];
                    n_chain  = adv_cnt;
                    n_state  = S_HEAD;
                end else begin
                    finish = 1'b1;
                end
            end
            S_ENTRY: begin
                if (32'(r_count) >= 32'(MAX_MATCHES_PER_BYTE)) begin
                    finish = 1'b1;
                    trunc  = 1'b1;
                end else if (!r_pend_valid || slot_free) begin
                    // The previous match is now known not to be the last one.
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_end   = r_end;
                        n_out_pat   = r_pend_pat;
                        n_out_last  = 1'b0;
                        n_out_trunc = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_pat   = ent_rd[PAT_WIDTH-1:0];
                    n_count      = r_count + CNT_W'(1);
                    n_ent        = ent_inc;
                    if (ent_nx_ok && 32'(ent_inc) < 32'(OUTPUT_ENTRIES)) begin
                        ent_re    = 1'b1;
                        ent_raddr = ent_rd[PAT_WIDTH+EAW-1:PAT_WIDTH];
                    end else begin
                        n_state = S_NEXT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // End of a byte: the held match goes out as the last of its run.
        if (finish && (!r_pend_valid || slot_free)) begin
            if (r_pend_valid) begin
                n_out_valid = 1'b1;
                n_out_end   = r_end;
                n_out_pat   = r_pend_pat;
                n_out_last  = 1'b1;
                n_out_trunc = trunc;
            end
            n_pend_valid = 1'b0;
            n_state      = S_IDLE;
            done         = 1'b1;
        end

        if (done && i_cmd_valid) begin
            o_cmd_pop = 1'b1;
            case (i_cmd.op)
                OP_SCAN: begin
                    n_end    = r_pos;
                    n_pos    = (r_pos == '1) ? r_pos : r_pos + POS_WIDTH'(1);
                    n_sym_ok = 32'(i_cmd.sym) < 32'(ALPHABET);
                    goto_re  = n_sym_ok;
                    n_state  = S_GOTO;
                end
                OP_GOTO:    goto_we = 1'b1;
                OP_HEAD:    head_we = 1'b1;
                OP_SUFFIX:  suf_we  = 1'b1;
                OP_ENTRY:   ent_we  = 1'b1;
                OP_RESTART: begin
                    n_cur = '0;
                    n_pos = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cur        <= '0;
            r_pos        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur        <= n_cur;
            r_pos        <= n_pos;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end       <= n_end;
        r_sym_ok    <= n_sym_ok;
        r_chain     <= n_chain;
        r_ent       <= n_ent;
        r_count     <= n_count;
        r_pend_pat  <= n_pend_pat;
        r_out_end   <= n_out_end;
        r_out_pat   <= n_out_pat;
        r_out_last  <= n_out_last;
        r_out_trunc <= n_out_trunc;
    end

    mpbm_ram #(.WIDTH(STATE_WIDTH), .DEPTH(GOTO_DEPTH)) u_goto_ram (
        .i_clk   (i_clk),
        .i_we    (goto_we),
        .i_waddr (goto_waddr),
        .i_wdata (goto_wdata),
        .i_re    (goto_re),
        .i_raddr (goto_raddr),
        .o_rdata (goto_rd)
    );

    mpbm_ram #(.WIDTH(LINK_WIDTH), .DEPTH(STATE_N)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (i_cmd.sidx[SAW-1:0]),
        .i_wdata (i_cmd.link),
        .i_re    (hs_re),
        .i_raddr (hs_raddr),
        .o_rdata (head_rd)
    );

    mpbm_ram #(.WIDTH(LINK_WIDTH), .DEPTH(STATE_N)) u_suffix_ram (
        .i_clk   (i_clk),
        .i_we    (suf_we),
        .i_waddr (i_cmd.sidx[SAW-1:0]),
        .i_wdata (i_cmd.link),
        .i_re    (hs_re),
        .i_raddr (hs_raddr),
        .o_rdata (suf_rd)
    );

    mpbm_ram #(.WIDTH(ENTRY_WIDTH), .DEPTH(ENTRY_N)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (i_cmd.eidx[EAW-1:0]),
        .i_wdata ({i_cmd.link, i_cmd.pattern}),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rd)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.match_end     = r_out_end;
    assign o_out.match_pattern = r_out_pat;
    assign o_out.last_of_run   = r_out_last;
    assign o_out.truncated     = r_out_trunc;
endmodule

[src/multi_pattern_byte_matcher_core.sv]
// Top level of the Aho-Corasick multi-pattern byte matcher.
// Depends on mpbm_pkg, mpbm_if, mpbm_front, mpbm_fifo and mpbm_back.
//
//   Channel   Direction  Handshake      Beat carries
//   i_in      in         valid/ready    opcode, scan_byte, state_index, entry_index,
//                                       link_value, link_valid, pattern_number
//   o_out     out        valid/ready    match_end, match_pattern, last_of_run, truncated
//
// A load or restart beat is carried out once the back end is free. A scan byte that
// ends no pattern takes a registered read of the transition table, then a read of
// the own-list head and suffix link of the new state. Each further state on the
// suffix chain adds such a read, each output entry a read of the entry table, and
// a state whose list was walked one more step, in series: each table has one read port.
// Reset (synchronous, active low) returns the automaton to the root state, clears
// the position and empties the queue; the tables keep whatever they held and must be
// loaded before use. The input side stalls only when the four-entry command queue
// is full; a result waiting in the output register stalls the walk, not the input.
module multi_pattern_byte_matcher_core #(
    parameter int STATE_COUNT          = mpbm_pkg::STATE_COUNT_DEF,
    parameter int ALPHABET             = mpbm_pkg::ALPHABET_DEF,
    parameter int OUTPUT_ENTRIES       = mpbm_pkg::OUTPUT_ENTRIES_DEF,
    parameter int MAX_MATCHES_PER_BYTE = mpbm_pkg::MAX_MATCHES_PER_BYTE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpbm_in_if.sink     i_in,
    mpbm_out_if.source  o_out
);
    import mpbm_pkg::*;

    // Front end to queue: classified commands, already stripped of no-op items.
    logic push;
    logic full;
    t_cmd push_cmd;

    // Queue to back end: the oldest command and its pop strobe.
    logic head_valid;
    logic pop;
    t_cmd head_cmd;

    mpbm_front #(
        .STATE_COUNT    (STATE_COUNT),
        .ALPHABET       (ALPHABET),
        .OUTPUT_ENTRIES (OUTPUT_ENTRIES)
    ) u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    mpbm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    // The back end holds the most recent match until it knows whether another
    // one follows, so the last-of-run flag lands on the right beat.
    mpbm_back #(
        .STATE_COUNT          (STATE_COUNT),
        .ALPHABET             (ALPHABET),
        .OUTPUT_ENTRIES       (OUTPUT_ENTRIES),
        .MAX_MATCHES_PER_BYTE (MAX_MATCHES_PER_BYTE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (pop),
        .o_out       (o_out)
    );
endmodule

[dv/mpbm_match_checker.sv]
`timescale 1ns / 1ps
// Match checker for the multi-pattern byte matcher: mirrors the four tables, predicts
// the matches of each scan byte and compares them with the result channel.
// Depends on mpbm_pkg and the channel interfaces in mpbm_if.
module mpbm_match_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mpbm_in_if   i_cmd,
    mpbm_out_if  i_match,
    output int   o_fail_count,
    output int   o_matches_waiting,
    output int   o_matches_checked,
    output int   o_capped_runs,
    output int   o_bytes_scanned
);
    import mpbm_pkg::*;

    typedef struct packed {
        logic [POS_WIDTH-1:0] end_pos;
        logic [PAT_WIDTH-1:0] pattern;
        logic                 last;
        logic                 cut;
    } match_rec_t;

    // Mirror of the automaton. Link words keep the valid flag in the top bit.
    bit [STATE_WIDTH-1:0] goto_next  [0:STATE_COUNT_DEF*ALPHABET_DEF-1];
    bit [LINK_WIDTH-1:0]  head_link  [0:STATE_COUNT_DEF-1];
    bit [LINK_WIDTH-1:0]  suffix_ptr [0:STATE_COUNT_DEF-1];
    bit [ENTRY_WIDTH-1:0] slot_word  [0:OUTPUT_ENTRIES_DEF-1];
    logic [STATE_WIDTH-1:0] cur_state;
    logic [POS_WIDTH-1:0]   position;

    match_rec_t awaited [$];
    match_rec_t want;
    match_rec_t seen;

    initial begin
        o_fail_count      = 0;
        o_matches_waiting = 0;
        o_matches_checked = 0;
        o_capped_runs     = 0;
        o_bytes_scanned   = 0;
        cur_state         = '0;
        position          = '0;
    end

    task automatic report(input string what, input match_rec_t got, input match_rec_t exp_rec);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t: %s: expected end=%0d pattern=%h last=%b truncated=%b, got end=%0d pattern=%h last=%b truncated=%b",
                     $time, what, exp_rec.end_pos, exp_rec.pattern, exp_rec.last, exp_rec.cut,
                     got.end_pos, got.pattern, got.last, got.cut);
        end
    endtask

    // Steps the automaton on one byte, then walks the dictionary-suffix chain from the
    // new state and queues one match per output entry, up to the per-byte cap. The
    // newest match is held back so that the final one can be marked.
    task automatic step_on_byte(input logic [SYM_WIDTH-1:0] sym);
        match_rec_t held;
        logic have_held;
        logic [POS_WIDTH-1:0] end_pos;
        logic [STATE_WIDTH-1:0] node;
        logic [STATE_WIDTH-1:0] slot;
        logic [LINK_WIDTH-1:0] link;
        logic [ENTRY_WIDTH-1:0] word;
        logic more_nodes;
        logic more_slots;
        logic cut;
        int node_steps;
        int slot_steps;
        int emitted;
        end_pos = position;
        cur_state = goto_next[{cur_state, sym}];
        if (position != '1) position = position + 1'b1;
        node = cur_state;
        more_nodes = 1'b1;
        cut = 1'b0;
        have_held = 1'b0;
        held = '0;
        node_steps = 0;
        slot_steps = 0;
        emitted = 0;
        while (more_nodes && node_steps < STATE_COUNT_DEF && !cut) begin
            link = head_link[node];
            more_slots = link[LINK_WIDTH-1];
            slot = link[STATE_WIDTH-1:0];
            node_steps++;
            while (more_slots && slot_steps < OUTPUT_ENTRIES_DEF && !cut) begin
                word = slot_word[slot];
                slot_steps++;
                if (emitted >= MAX_MATCHES_PER_BYTE_DEF) begin
                    cut = 1'b1;
                end else begin
                    if (have_held) awaited.push_back(held);
                    held.end_pos = end_pos;
                    held.pattern = word[PAT_WIDTH-1:0];
                    held.last = 1'b0;
                    held.cut = 1'b0;
                    have_held = 1'b1;
                    emitted++;
                    more_slots = word[ENTRY_WIDTH-1];
                    slot = word[PAT_WIDTH +: STATE_WIDTH];
                end
            end
            link = suffix_ptr[node];
            more_nodes = link[LINK_WIDTH-1];
            node = link[STATE_WIDTH-1:0];
        end
        if (have_held) begin
            held.last = 1'b1;
            held.cut = cut;
            awaited.push_back(held);
        end
    endtask

    task automatic apply_command();
        logic [LINK_WIDTH-1:0] link;
        link = {i_cmd.link_valid, i_cmd.link_value};
        case (i_cmd.opcode)
            OP_SCAN: begin
                o_bytes_scanned++;
                step_on_byte(i_cmd.scan_byte);
            end
            OP_GOTO: begin
                goto_next[{i_cmd.state_index, i_cmd.scan_byte}] =
                    i_cmd.link_valid ? i_cmd.link_value : '0;
            end
            OP_HEAD:    head_link[i_cmd.state_index] = link;
            OP_SUFFIX:  suffix_ptr[i_cmd.state_index] = link;
            OP_ENTRY:   slot_word[i_cmd.entry_index] = {link, i_cmd.pattern_number};
            OP_RESTART: begin
                cur_state = '0;
                position = '0;
            end
            default: ;
        endcase
    endtask

    // Results are compared before the new beat is applied: a result can never belong
    // to a beat accepted at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_state = '0;
            position = '0;
        end else begin
            if (i_match.valid === 1'b1 && i_match.ready === 1'b1) begin
                seen.end_pos = i_match.match_end;
                seen.pattern = i_match.match_pattern;
                seen.last = i_match.last_of_run;
                seen.cut = i_match.truncated;
                if (awaited.size() == 0) begin
                    report("match with none awaited", seen, '0);
                end else begin
                    want = awaited.pop_front();
                    o_matches_checked++;
                    if (seen.cut === 1'b1) o_capped_runs++;
                    if (seen !== want) report("match mismatch", seen, want);
                end
            end
            if (i_cmd.valid === 1'b1 && i_cmd.ready === 1'b1) apply_command();
            o_matches_waiting = awaited.size();
        end
    end

endmodule

[dv/tb_multi_pattern_byte_matcher_core.sv]
`timescale 1ns / 1ps
// Top of the multi-pattern byte matcher testbench: loads small automata, scans text
// and drives both handshakes with random gaps. Needs the RTL and mpbm_match_checker.
module tb_multi_pattern_byte_matcher_core;
    import mpbm_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 100;
    localparam int IDLE_PERCENT  = 23;
    // A scan that ends nothing can still walk a long suffix chain after the last
    // result, so the closing wait covers a full walk of every state.
    localparam int SETTLE_CYCLES = 2500;
    localparam int NODES         = 5;
    localparam int SLOTS         = 8;
    localparam int HOT_SYMS      = 4;
    localparam int COLD_SYMS     = 4;

    // One input beat, field by field.
    typedef struct packed {
        logic [OPCODE_WIDTH-1:0] op;
        logic [SYM_WIDTH-1:0]    sym;
        logic [STATE_WIDTH-1:0]  sidx;
        logic [STATE_WIDTH-1:0]  eidx;
        logic [STATE_WIDTH-1:0]  lval;
        logic                    lvld;
        logic [PAT_WIDTH-1:0]    pat;
    } t_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mpbm_in_if  cmd_ch ();
    mpbm_out_if match_ch ();

    int fail_count;
    int matches_waiting;
    int matches_checked;
    int capped_runs;
    int bytes_scanned;
    int beats_sent = 0;
    int cycle_count = 0;
    // While set, neither side inserts gaps.
    bit steady = 1'b0;

    // The automaton only ever lives on these states and output slots. The text only
    // uses the hot and cold symbols, and every column of those symbols is written for
    // every state here before the first scan, so no scan can read an unwritten entry.
    // The first state is the root and the second the highest index; the first two
    // slots likewise sit at both ends of the slot range.
    bit [STATE_WIDTH-1:0] node_id  [NODES];
    bit [STATE_WIDTH-1:0] slot_id  [SLOTS];
    // Symbols that move between states, so that the text reaches deep into the trie.
    bit [SYM_WIDTH-1:0]   hot_sym  [HOT_SYMS];
    // Fixed symbols that mostly fall back to the root, both ends of the range included.
    bit [SYM_WIDTH-1:0]   cold_sym [COLD_SYMS];

    multi_pattern_byte_matcher_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (match_ch)
    );

    mpbm_match_checker match_chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd_ch),
        .i_match           (match_ch),
        .o_fail_count      (fail_count),
        .o_matches_waiting (matches_waiting),
        .o_matches_checked (matches_checked),
        .o_capped_runs     (capped_runs),
        .o_bytes_scanned   (bytes_scanned)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d matches still awaited",
                     cycle_count, matches_waiting);
            $display("multi_pattern_byte_matcher_core test failed");
            $finish;
        end
    end

    // The result side stalls on about a quarter of the cycles unless the run is steady.
    always @(negedge i_clk) begin
        match_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Every field but the opcode random; callers overwrite what the opcode uses, so the unused
    // fields carry noise that the block must ignore.
    function automatic t_beat junk_beat();
        t_beat b;
        b.op   = OP_SCAN;
        b.sym  = SYM_WIDTH'($urandom);
        b.sidx = STATE_WIDTH'($urandom);
        b.eidx = STATE_WIDTH'($urandom);
        b.lval = STATE_WIDTH'($urandom);
        b.lvld = 1'($urandom);
        b.pat  = PAT_WIDTH'($urandom);
        return b;
    endfunction

    function automatic bit [STATE_WIDTH-1:0] any_node();
        return node_id[$urandom_range(NODES - 1)];
    endfunction

    function automatic bit [SYM_WIDTH-1:0] any_cold();
        return cold_sym[$urandom_range(COLD_SYMS - 1)];
    endfunction

    function automatic bit is_hot(input bit [SYM_WIDTH-1:0] sym);
        for (int k = 0; k < HOT_SYMS; k++) begin
            if (hot_sym[k] == sym) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat was taken.
    // Valid stays high from one beat to the next unless a gap is drawn.
    task automatic send_beat(input t_beat b);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            cmd_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.opcode         = b.op;
        cmd_ch.scan_byte      = b.sym;
        cmd_ch.state_index    = b.sidx;
        cmd_ch.entry_index    = b.eidx;
        cmd_ch.link_value     = b.lval;
        cmd_ch.link_valid     = b.lvld;
        cmd_ch.pattern_number = b.pat;
        cmd_ch.valid          = 1'b1;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        @(negedge i_clk);
        beats_sent++;
    endtask

    task automatic put_goto(input bit [STATE_WIDTH-1:0] st, input bit [SYM_WIDTH-1:0] sym,
                            input bit [STATE_WIDTH-1:0] tgt, input bit vld);
        t_beat b;
        b = junk_beat();
        b.op = OP_GOTO;
        b.sidx = st;
        b.sym = sym;
        b.lval = tgt;
        b.lvld = vld;
        send_beat(b);
    endtask

    task automatic put_head(input bit [STATE_WIDTH-1:0] st, input bit [STATE_WIDTH-1:0] slot,
                            input bit vld);
        t_beat b;
        b = junk_beat();
        b.op = OP_HEAD;
        b.sidx = st;
        b.lval = slot;
        b.lvld = vld;
        send_beat(b);
    endtask

    task automatic put_suffix(input bit [STATE_WIDTH-1:0] st, input bit [STATE_WIDTH-1:0] tgt,
                              input bit vld);
        t_beat b;
        b = junk_beat();
        b.op = OP_SUFFIX;
        b.sidx = st;
        b.lval = tgt;
        b.lvld = vld;
        send_beat(b);
    endtask

    task automatic put_slot(input bit [STATE_WIDTH-1:0] idx, input bit [STATE_WIDTH-1:0] nxt,
                            input bit vld, input bit [PAT_WIDTH-1:0] pat);
        t_beat b;
        b = junk_beat();
        b.op = OP_ENTRY;
        b.eidx = idx;
        b.lval = nxt;
        b.lvld = vld;
        b.pat = pat;
        send_beat(b);
    endtask

    task automatic put_scan(input bit [SYM_WIDTH-1:0] sym);
        t_beat b;
        b = junk_beat();
        b.op = OP_SCAN;
        b.sym = sym;
        send_beat(b);
    endtask

    task automatic put_restart();
        t_beat b;
        b = junk_beat();
        b.op = OP_RESTART;
        send_beat(b);
    endtask

    // Hot symbols always lead to a known state; other symbols mostly fall back to
    // the root through a nil link whose value is noise.
    task automatic put_rule_goto(input int i, input bit [SYM_WIDTH-1:0] sym);
        if (is_hot(sym) || $urandom_range(99) < 20) begin
            put_goto(node_id[i], sym, any_node(), 1'b1);
        end else begin
            put_goto(node_id[i], sym, STATE_WIDTH'($urandom), 1'b0);
        end
    endtask

    task automatic put_rule_head(input int i);
        if ($urandom_range(99) < 65) begin
            put_head(node_id[i], slot_id[$urandom_range(SLOTS - 1)], 1'b1);
        end else begin
            put_head(node_id[i], STATE_WIDTH'($urandom), 1'b0);
        end
    endtask

    // Suffix links only point to states earlier in the list, so chains never loop.
    task automatic put_rule_suffix(input int i);
        if (i > 0 && $urandom_range(99) < 70) begin
            put_suffix(node_id[i], node_id[$urandom_range(i - 1)], 1'b1);
        end else begin
            put_suffix(node_id[i], STATE_WIDTH'($urandom), 1'b0);
        end
    endtask

    // Output lists only link forward through the slot list, so they never loop.
    task automatic put_rule_slot(input int j);
        if (j < SLOTS - 1 && $urandom_range(99) < 60) begin
            put_slot(slot_id[j], slot_id[$urandom_range(SLOTS - 1, j + 1)], 1'b1,
                     PAT_WIDTH'($urandom));
        end else begin
            put_slot(slot_id[j], STATE_WIDTH'($urandom), 1'b0, PAT_WIDTH'($urandom));
        end
    endtask

    task automatic pick_hot_syms();
        for (int k = 0; k < HOT_SYMS; k++) begin
            hot_sym[k] = SYM_WIDTH'(k * 64 + $urandom_range(63));
        end
    endtask

    // Writes a fresh, loop-free automaton. The full form also writes the cold columns
    // of every state; the short form only redirects the current hot symbols, since
    // the cold columns are already written.
    task automatic load_structure(input bit full_rows);
        for (int i = 0; i < NODES; i++) begin
            if (full_rows) begin
                for (int k = 0; k < COLD_SYMS; k++) put_rule_goto(i, cold_sym[k]);
            end
            for (int k = 0; k < HOT_SYMS; k++) begin
                put_goto(node_id[i], hot_sym[k], any_node(), 1'b1);
            end
        end
        for (int j = 0; j < SLOTS; j++) put_rule_slot(j);
        for (int i = 0; i < NODES; i++) begin
            put_rule_head(i);
            put_rule_suffix(i);
        end
    endtask

    // Holds the sender back until every predicted match has come out.
    task automatic wait_drained();
        cmd_ch.valid = 1'b0;
        do @(negedge i_clk); while (matches_waiting != 0);
    endtask

    initial begin
        int roll;
        cmd_ch.valid          = 1'b0;
        cmd_ch.opcode         = OP_SCAN;
        cmd_ch.scan_byte      = '0;
        cmd_ch.state_index    = '0;
        cmd_ch.entry_index    = '0;
        cmd_ch.link_value     = '0;
        cmd_ch.link_valid     = 1'b0;
        cmd_ch.pattern_number = '0;
        match_ch.ready        = 1'b0;

        // States, and likewise slots, come from disjoint ranges, so each set is distinct.
        node_id[0] = '0;
        node_id[1] = '1;
        for (int k = 2; k < NODES; k++) begin
            node_id[k] = STATE_WIDTH'((k - 2) * 256 + 1 + $urandom_range(253));
        end
        slot_id[0] = '0;
        slot_id[1] = '1;
        for (int j = 2; j < SLOTS; j++) begin
            slot_id[j] = STATE_WIDTH'((j - 2) * 100 + 1 + $urandom_range(99));
        end
        cold_sym[0] = '0;
        cold_sym[1] = '1;
        for (int k = 2; k < COLD_SYMS; k++) begin
            cold_sym[k] = SYM_WIDTH'(64 + $urandom_range(127));
        end
        pick_hot_syms();

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        load_structure(1'b1);

        // Directed part. Both ends of the symbol range from the root.
        put_restart();
        put_scan('0);
        put_scan('1);
        // A nil goto leads back to the root even with a nonzero link value.
        put_goto(node_id[0], hot_sym[0], '1, 1'b0);
        put_restart();
        put_scan(hot_sym[0]);
        // Two-entry list on the highest state with both extreme pattern ids; the
        // restart puts the match at position zero.
        put_slot(slot_id[1], STATE_WIDTH'($urandom), 1'b0, '1);
        put_slot(slot_id[0], slot_id[1], 1'b1, '0);
        put_head(node_id[1], slot_id[0], 1'b1);
        put_suffix(node_id[1], STATE_WIDTH'($urandom), 1'b0);
        put_goto(node_id[0], hot_sym[1], node_id[1], 1'b1);
        put_restart();
        put_scan(hot_sym[1]);
        // An output entry that links to itself: the walk stops at the match cap and
        // the final match is flagged truncated.
        put_slot(slot_id[2], slot_id[2], 1'b1, PAT_WIDTH'($urandom));
        put_head(node_id[2], slot_id[2], 1'b1);
        put_goto(node_id[1], hot_sym[2], node_id[2], 1'b1);
        put_scan(hot_sym[2]);
        // Two states whose suffix links point at each other with empty lists: the
        // walk runs to its state limit and yields nothing, then scanning goes on.
        put_head(node_id[3], STATE_WIDTH'($urandom), 1'b0);
        put_head(node_id[4], STATE_WIDTH'($urandom), 1'b0);
        put_suffix(node_id[3], node_id[4], 1'b1);
        put_suffix(node_id[4], node_id[3], 1'b1);
        put_goto(node_id[2], hot_sym[3], node_id[3], 1'b1);
        put_scan(hot_sym[3]);
        put_scan(any_cold());

        // Back to a loop-free automaton before the random text.
        wait_drained();
        load_structure(1'b0);

        // Random part: mostly text biased to the hot symbols, some restarts and single
        // table rewrites that keep the automaton loop-free. Halfway the sender drains
        // the block and a new set of hot symbols is loaded.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                wait_drained();
                pick_hot_syms();
                load_structure(1'b0);
            end
            steady = (n >= 60 && n < 90);
            roll = $urandom_range(99);
            if (roll < 72) begin
                if ($urandom_range(99) < 80) begin
                    put_scan(hot_sym[$urandom_range(HOT_SYMS - 1)]);
                end else begin
                    put_scan(any_cold());
                end
            end else if (roll < 76) begin
                put_restart();
            end else begin
                case ($urandom_range(3))
                    0: put_rule_goto($urandom_range(NODES - 1), any_cold());
                    1: put_rule_head($urandom_range(NODES - 1));
                    2: put_rule_suffix($urandom_range(NODES - 1));
                    default: put_rule_slot($urandom_range(SLOTS - 1));
                endcase
            end
        end
        steady = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Run covered %0d beats with %0d scan bytes;", beats_sent, bytes_scanned);
        $display("%0d matches compared, %0d at the cap.", matches_checked, capped_runs);
        if (fail_count == 0) begin
            $display("multi_pattern_byte_matcher_core test passed");
        end else begin
            $display("%0d failures seen", fail_count);
            $display("multi_pattern_byte_matcher_core test failed");
        end
        $finish;
    end

endmodule

[files.f]
src/mpbm_pkg.sv
src/mpbm_if.sv
src/mpbm_ram.sv
src/mpbm_front.sv
src/mpbm_fifo.sv
src/mpbm_back.sv
src/multi_pattern_byte_matcher_core.sv
dv/mpbm_match_checker.sv
dv/tb_multi_pattern_byte_matcher_core.sv
